/* hdl/cba_pkg.sv */
// ----------------------------------------------------------------------------
// Contiguous block allocator package
// Transfer types and status codes shared by the allocator and its users.
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_RUN = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] run_len;
    logic [14:0] first_block;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [14:0] base_block;
  } out_item_t;

endpackage

/* hdl/contiguous_block_allocator.sv */
// ----------------------------------------------------------------------------
// Contiguous block allocator
// First-fit allocator of contiguous block runs over a one-bit-per-block map.
// ----------------------------------------------------------------------------
// A request transfer happens when start is high and busy is low. An allocate
// scans the map upward from block 0 for the lowest free run of run_len blocks,
// marks it used and returns its first block. A release clears a given run.
// Every request yields exactly one result, shown on out_item for a single
// cycle while out_valid is high; the receiver cannot stall it.
// The map is a memory of 32-bit words, read one word per cycle. An allocate
// scans words until one completes a run, then rewrites the run's words and
// shows its result; one that finds no run shows it once the last word is
// scanned. A release rewrites the words of its run, then shows its result.
// Zero-length requests, oversized allocates and out-of-range releases answer
// on the next cycle with busy low. Otherwise busy stays high until the result
// shows, and the next request can transfer at the edge that ends the result
// cycle. After reset, busy stays high while the map is cleared word by word.
// ----------------------------------------------------------------------------
module contiguous_block_allocator #(
  parameter int NUM_BLOCKS = 32768
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cba_pkg::in_item_t  in_item,
  output logic               out_valid,
  output cba_pkg::out_item_t out_item
);

  localparam int NUM_WORDS = (NUM_BLOCKS + 31) / 32;
  localparam int WAW       = $clog2(NUM_WORDS);
  localparam int IW        = WAW + 5;
  localparam int AW        = (IW + 1 > 17) ? IW + 1 : 17;
  localparam int TAIL      = NUM_BLOCKS % 32;
  localparam logic [31:0] TAIL_MASK = (TAIL == 0) ? 32'd0 : ~((32'd1 << TAIL) - 32'd1);
  localparam logic [WAW-1:0] LAST_W = WAW'(NUM_WORDS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t             state_r, state_nxt;
  logic [WAW-1:0]     w_r, w_nxt;
  logic               iss_r, iss_nxt;
  logic               q_vld_r, q_vld_nxt;
  logic [WAW-1:0]     q_w_r, q_w_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      len_r, len_nxt;
  logic [IW-1:0]      lo_r, lo_nxt;
  logic [IW-1:0]      hi_r, hi_nxt;
  logic               set_r, set_nxt;
  logic               out_valid_r, out_valid_nxt;
  cba_pkg::out_item_t out_item_r, out_item_nxt;

  logic [31:0]    mem [NUM_WORDS];
  logic [31:0]    mem_q_r;
  logic [WAW-1:0] raddr;
  logic           we;
  logic [WAW-1:0] waddr;
  logic [31:0]    wdata;

  logic [31:0]   used_w;
  logic [31:0]   pf;
  logic [4:0]    lu [32];
  logic [31:0]   hit;
  logic [4:0]    hit_j;
  logic [AW-1:0] need;
  logic [AW-1:0] req_cnt;
  logic [AW-1:0] req_end;
  logic [AW-1:0] cand;
  logic [4:0]    lb;
  logic [4:0]    hb;
  logic [31:0]   amask;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign raddr     = w_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q_r <= mem[raddr];
  end

  always_comb begin
    used_w = mem_q_r | ((q_w_r == LAST_W) ? TAIL_MASK : 32'd0);
    need   = (cnt_r > len_r) ? cnt_r - len_r : '0;
    for (int j = 0; j < 32; j++) begin
      pf[j] = 1'b1;
      lu[j] = 5'd0;
      for (int k = 0; k < 32; k++) begin
        if (k <= j && used_w[k]) begin
          pf[j] = 1'b0;
          lu[j] = 5'(k);
        end
      end
      hit[j] = !used_w[j] &&
               (pf[j] ? (AW'(j + 1) >= need) : (cnt_r <= AW'(5'(j) - lu[j])));
    end
    hit_j = 5'd0;
    for (int j = 31; j >= 0; j--) begin
      if (hit[j]) begin
        hit_j = 5'(j);
      end
    end
    cand = AW'({q_w_r, hit_j}) + AW'(1) - cnt_r;
    lb    = (q_w_r == lo_r[IW-1:5]) ? lo_r[4:0] : 5'd0;
    hb    = (q_w_r == hi_r[IW-1:5]) ? hi_r[4:0] : 5'd31;
    amask = ({32{1'b1}} << lb) & ({32{1'b1}} >> (5'd31 - hb));
    req_cnt = AW'(in_item.run_len);
    req_end = AW'(in_item.first_block) + req_cnt;
  end

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    iss_nxt       = iss_r;
    q_vld_nxt     = 1'b0;
    q_w_nxt       = w_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    set_nxt       = set_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    we            = 1'b0;
    waddr         = w_r;
    wdata         = 32'd0;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        if (w_r == LAST_W) begin
          w_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          w_nxt = w_r + WAW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          out_item_nxt.base_block = 15'd0;
          out_item_nxt.status     = cba_pkg::ST_OK;
          cnt_nxt                 = req_cnt;
          len_nxt                 = '0;
          w_nxt                   = '0;
          iss_nxt                 = 1'b1;
          if (in_item.kind == cba_pkg::KIND_ALLOC) begin
            set_nxt = 1'b1;
            if (req_cnt == '0) begin
              out_valid_nxt = 1'b1;
            end else if (req_cnt > AW'(NUM_BLOCKS)) begin
              out_item_nxt.status = cba_pkg::ST_NO_RUN;
              out_valid_nxt       = 1'b1;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            set_nxt = 1'b0;
            if (req_end > AW'(NUM_BLOCKS)) begin
              out_item_nxt.status = cba_pkg::ST_RANGE;
              out_valid_nxt       = 1'b1;
            end else if (req_cnt == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              lo_nxt    = IW'(in_item.first_block);
              hi_nxt    = IW'(req_end - AW'(1));
              w_nxt     = lo_nxt[IW-1:5];
              state_nxt = S_APPLY;
            end
          end
        end
      end
      S_SCAN: begin
        if (iss_r) begin
          q_vld_nxt = 1'b1;
          if (w_r == LAST_W) begin
            iss_nxt = 1'b0;
          end else begin
            w_nxt = w_r + WAW'(1);
          end
        end
        if (q_vld_r) begin
          if (|hit) begin
            lo_nxt                  = IW'(cand);
            hi_nxt                  = {q_w_r, hit_j};
            out_item_nxt.base_block = 15'(cand);
            w_nxt                   = lo_nxt[IW-1:5];
            iss_nxt                 = 1'b1;
            q_vld_nxt               = 1'b0;
            state_nxt               = S_APPLY;
          end else if (q_w_r == LAST_W) begin
            out_item_nxt.status = cba_pkg::ST_NO_RUN;
            out_valid_nxt       = 1'b1;
            q_vld_nxt           = 1'b0;
            state_nxt           = S_IDLE;
          end else begin
            len_nxt = pf[31] ? len_r + AW'(32) : AW'(5'd31 - lu[31]);
          end
        end
      end
      S_APPLY: begin
        if (iss_r) begin
          q_vld_nxt = 1'b1;
          if (w_r == hi_r[IW-1:5]) begin
            iss_nxt = 1'b0;
          end else begin
            w_nxt = w_r + WAW'(1);
          end
        end
        if (q_vld_r) begin
          we    = 1'b1;
          waddr = q_w_r;
          wdata = set_r ? (mem_q_r | amask) : (mem_q_r & ~amask);
          if (q_w_r == hi_r[IW-1:5]) begin
            out_valid_nxt = 1'b1;
            q_vld_nxt     = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      w_r         <= '0;
      iss_r       <= 1'b0;
      q_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      iss_r       <= iss_nxt;
      q_vld_r     <= q_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_w_r      <= q_w_nxt;
    cnt_r      <= cnt_nxt;
    len_r      <= len_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    set_r      <= set_nxt;
    out_item_r <= out_item_nxt;
  end

  // The map is never touched by a request while it is still being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result transfer during map clear");

  // A failed allocate or a rejected release never reports a start block.
  a_fail_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status != cba_pkg::ST_OK)
    |-> (out_item_r.base_block == 15'd0))
    else $error("failed request reports a nonzero start block");

  // An allocate that needs a scan keeps the block busy on the next cycle.
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == cba_pkg::KIND_ALLOC &&
     in_item.run_len != 16'd0 && AW'(in_item.run_len) <= AW'(NUM_BLOCKS))
    |=> (busy && !out_valid_r))
    else $error("allocate answered without a scan");

  // Map words are written only while clearing or rewriting a run.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLEAR || state_r == S_APPLY))
    else $error("map write outside clear or rewrite");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous block allocator testbench
// Drives directed edge-case requests, then allocate and release requests in random bursts.
// A bit-per-block copy of the usage map predicts the status and start block
// of every result. Results are checked in order of their requests.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_BLK = 32768;
  localparam int N_RANDOM = 560;

  typedef struct {
    int unsigned first;
    int unsigned len;
  } live_run_t;

  class block_map_checker_t;
    bit                 used_map [NUM_BLK];
    cba_pkg::out_item_t pending_results [$];
    int unsigned        errors;
    int unsigned        n_alloc;
    int unsigned        n_release;
    int unsigned        n_ok;
    int unsigned        n_no_run;
    int unsigned        n_range;

    task report(string what);
      errors++;
      $display("%0t: mismatch: %s", $time, what);
    endtask

    function cba_pkg::out_item_t log_request(cba_pkg::in_item_t req);
      int unsigned        cnt;
      int unsigned        first;
      int unsigned        len;
      int unsigned        cand;
      int unsigned        b;
      bit                 found;
      cba_pkg::out_item_t res;
      cnt = 32'(req.run_len);
      first = 32'(req.first_block);
      len = 0;
      cand = 0;
      found = 1'b0;
      res.status = cba_pkg::ST_OK;
      res.base_block = '0;
      if (req.kind == cba_pkg::KIND_ALLOC) begin
        n_alloc++;
        if (cnt != 0 && cnt <= NUM_BLK) begin
          for (b = 0; b < NUM_BLK; b++) begin
            if (used_map[b]) begin
              len = 0;
            end else begin
              if (len == 0) cand = b;
              len++;
              if (len == cnt) begin
                found = 1'b1;
                break;
              end
            end
          end
        end
        if (cnt != 0) begin
          if (found) begin
            for (b = cand; b < cand + cnt; b++) used_map[b] = 1'b1;
            res.base_block = 15'(cand);
          end else begin
            res.status = cba_pkg::ST_NO_RUN;
          end
        end
      end else begin
        n_release++;
        if (first + cnt > NUM_BLK) begin
          res.status = cba_pkg::ST_RANGE;
        end else begin
          for (b = first; b < first + cnt; b++) used_map[b] = 1'b0;
        end
      end
      pending_results.push_back(res);
      return res;
    endfunction

    task check_result(cba_pkg::out_item_t got);
      cba_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result status %0d start %0d with no request waiting",
                         got.status, got.base_block));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.base_block !== want.base_block)
        report($sformatf("base_block %0d, expected %0d", got.base_block, want.base_block));
      case (want.status)
        cba_pkg::ST_OK:     n_ok++;
        cba_pkg::ST_NO_RUN: n_no_run++;
        default:            n_range++;
      endcase
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  cba_pkg::in_item_t  in_item;
  logic               out_valid;
  cba_pkg::out_item_t out_item;

  block_map_checker_t sb;
  live_run_t          live_runs [$];
  int unsigned        live_total;
  int unsigned        burst_left;

  contiguous_block_allocator #(
    .NUM_BLOCKS(NUM_BLK)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_item);
  end

  function automatic cba_pkg::in_item_t mk_req(logic kind, int unsigned cnt,
                                               int unsigned first);
    cba_pkg::in_item_t req;
    req.kind = kind;
    req.run_len = 16'(cnt);
    req.first_block = 15'(first);
    return req;
  endfunction

  function automatic int unsigned alloc_size();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return 0;
    if (pick < 70) return $urandom_range(1, 64);
    if (pick < 88) return $urandom_range(65, 1024);
    if (pick < 95) return $urandom_range(1025, 8192);
    return $urandom_range(8193, NUM_BLK);
  endfunction

  task automatic send_req(cba_pkg::in_item_t req);
    cba_pkg::out_item_t want;
    int unsigned        gap;
    start <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy !== 1'b0);
    want = sb.log_request(req);
    if (req.kind == cba_pkg::KIND_ALLOC && want.status == cba_pkg::ST_OK &&
        req.run_len != 16'd0) begin
      live_runs.push_back('{first: 32'(want.base_block), len: 32'(req.run_len)});
      live_total += 32'(req.run_len);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  task automatic send_random();
    int unsigned pick;
    int unsigned idx;
    int unsigned off;
    int unsigned first;
    live_run_t   r;
    pick = $urandom_range(0, 99);
    if (live_total > 20000 && live_runs.size() != 0) pick = 60;
    if (pick < 48) begin
      send_req(mk_req(cba_pkg::KIND_ALLOC, alloc_size(), $urandom_range(0, 32767)));
    end else if (pick < 52) begin
      send_req(mk_req(cba_pkg::KIND_ALLOC, $urandom_range(0, 65535),
                      $urandom_range(0, 32767)));
    end else if (pick < 82 && live_runs.size() != 0) begin
      idx = $urandom_range(0, live_runs.size() - 1);
      r = live_runs[idx];
      if ($urandom_range(0, 4) == 0) begin
        off = $urandom_range(0, r.len - 1);
        send_req(mk_req(cba_pkg::KIND_RELEASE, $urandom_range(1, r.len - off),
                        r.first + off));
      end else begin
        live_runs.delete(idx);
        live_total -= r.len;
        send_req(mk_req(cba_pkg::KIND_RELEASE, r.len, r.first));
      end
    end else if (pick < 82) begin
      send_req(mk_req(cba_pkg::KIND_ALLOC, $urandom_range(1, 64), $urandom_range(0, 32767)));
    end else if (pick < 92) begin
      send_req(mk_req(cba_pkg::KIND_RELEASE, $urandom_range(0, 64),
                      $urandom_range(0, 32767)));
    end else if (pick < 97) begin
      first = $urandom_range(0, 32767);
      send_req(mk_req(cba_pkg::KIND_RELEASE, NUM_BLK - first + $urandom_range(0, 1), first));
    end else begin
      send_req(mk_req(cba_pkg::KIND_RELEASE, $urandom_range(0, 65535),
                      $urandom_range(0, 32767)));
    end
  endtask

  initial begin
    sb = new();
    live_total = 0;
    burst_left = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Extremes of both fields, zero-length requests and runs at the map edges.
    send_req(mk_req(cba_pkg::KIND_ALLOC, 0, 0));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 1, 32767));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 65535, 0));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 32769, 0));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 32768, 0));
    send_req(mk_req(cba_pkg::KIND_RELEASE, 1, 0));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 32768, 0));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 1, 0));
    send_req(mk_req(cba_pkg::KIND_RELEASE, 1, 32767));
    send_req(mk_req(cba_pkg::KIND_RELEASE, 2, 32767));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 1, 0));
    send_req(mk_req(cba_pkg::KIND_RELEASE, 32768, 0));
    send_req(mk_req(cba_pkg::KIND_RELEASE, 32768, 1));
    send_req(mk_req(cba_pkg::KIND_RELEASE, 65535, 32767));
    send_req(mk_req(cba_pkg::KIND_RELEASE, 0, 32767));
    send_req(mk_req(cba_pkg::KIND_RELEASE, 10, 100));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 0, 32767));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 3, 32767));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 40, 0));
    send_req(mk_req(cba_pkg::KIND_RELEASE, 1, 1));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 2, 0));
    send_req(mk_req(cba_pkg::KIND_ALLOC, 1, 0));
    send_req(mk_req(cba_pkg::KIND_RELEASE, 32768, 0));
    drain();
    live_runs.delete();
    live_total = 0;

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain();
      send_random();
    end
    drain();
    repeat (50) @(posedge clk);

    $display("Checked %0d requests: %0d allocates and %0d releases.",
             sb.n_alloc + sb.n_release, sb.n_alloc, sb.n_release);
    $display("Outcomes: %0d ok, %0d with no free run, %0d out of range; %0d mismatches.",
             sb.n_ok, sb.n_no_run, sb.n_range, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/cba_pkg.sv
hdl/contiguous_block_allocator.sv
tb/sv/tb_top.sv
